/* hdl/crp_pkg.sv */
// Shared types and constants for the polynomial-from-roots block.
// No dependencies; every other file of the block imports this package.
package crp_pkg;

	// Width of one root component (signed Q2.14).
	localparam int ROOT_W = 16;
	// Width of the coefficient index on the output channel.
	localparam int INDEX_W = 5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic root_load;   // capture the root of the current input transfer
		logic step_issue;  // start one coefficient update step
		logic step_first;  // the step works on the topmost coefficient (old value zero)
		logic emit_read;   // read one stored coefficient for output
		logic out_load;    // load the output register from the read data
		logic out_last;    // the loaded coefficient closes the run
		logic out_ovf;     // run overflow flag to show with the coefficient
	} crp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;      // update steps still in flight
		logic sat;       // a written coefficient was saturated this cycle
		logic out_free;  // the output register can take a coefficient this cycle
	} crp_status_t;

endpackage

/* hdl/crp_if.sv */
// Channel interfaces of the polynomial-from-roots block: roots in, coefficients out.
// Depends on crp_pkg for the fixed field widths.
interface crp_root_if import crp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ROOT_W-1:0] root_real;
	logic signed [ROOT_W-1:0] root_imag;
	logic                     last_root;

	modport source (output valid, output root_real, output root_imag, output last_root,
		input ready);
	modport sink (input valid, input root_real, input root_imag, input last_root,
		output ready);
endinterface

interface crp_coef_if import crp_pkg::*; #(
	parameter int COEF_WIDTH = 48
) ();
	logic                         valid;
	logic                         ready;
	logic [INDEX_W-1:0]           coef_index;
	logic signed [COEF_WIDTH-1:0] coef_real;
	logic signed [COEF_WIDTH-1:0] coef_imag;
	logic                         last_coef;
	logic                         overflow;

	modport source (output valid, output coef_index, output coef_real, output coef_imag,
		output last_coef, output overflow, input ready);
	modport sink (input valid, input coef_index, input coef_real, input coef_imag,
		input last_coef, input overflow, output ready);
endinterface

/* hdl/complex_roots_to_polynomial_core.sv */
// Top level of the polynomial-from-roots block: controller plus datapath.
// Depends on crp_pkg, crp_if, crp_ctrl and crp_datapath.
//
// Usage: complex roots (Q2.14 real and imaginary parts) arrive on the root
// channel, one per transfer. Each root is multiplied into a stored complex
// polynomial that starts as 1. The root that carries last_root closes the
// run: the block then sends the k+1 coefficients (Q34.14 for the default
// width), leading coefficient first, on the coef channel, with last_coef on
// the final one and overflow on all of them if any coefficient saturated or
// a root beyond MAX_ROOTS was dropped. The store then returns to 1.
// One shared complex multiply-subtract pipeline (read, multiply, round,
// subtract and write back) handles one coefficient per cycle and is drained
// before the next root. Emission reads each coefficient through the single
// memory read port and then loads it into the output register. A new root
// is taken only while the block is idle; the output register lets the last
// coefficient wait for the receiver while the next root is already being
// worked in.
// Reset clears the root count, the overflow flag and all stage and output valid flags; the
// memory needs no clearing pass because entries above the count are never read.
// A stalled receiver simply holds the emission until each transfer completes.
module complex_roots_to_polynomial_core import crp_pkg::*; #(
	parameter int MAX_ROOTS  = 16,
	parameter int COEF_WIDTH = 48,
	parameter int FRAC_BITS  = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	crp_root_if.sink   root,
	crp_coef_if.source coef
);

	localparam int IDX_W = $clog2(MAX_ROOTS + 1);

	crp_cmd_t         cmd;
	crp_status_t      status;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] step_addr;
	logic [IDX_W-1:0] out_index;
	logic             in_ready;

	assign root.ready = in_ready;

	// The controller owns the root count, the overflow flag and the sequencing.
	crp_ctrl #(
		.MAX_ROOTS (MAX_ROOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root.valid),
		.last_root (root.last_root),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.step_addr (step_addr),
		.out_index (out_index)
	);

	// The datapath holds the coefficients and drives the coef channel.
	crp_datapath #(
		.MAX_ROOTS  (MAX_ROOTS),
		.COEF_WIDTH (COEF_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.root_real (root.root_real),
		.root_imag (root.root_imag),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.step_addr (step_addr),
		.out_index (out_index),
		.status    (status),
		.coef      (coef)
	);

endmodule

/* hdl/crp_ctrl.sv */
// Controller of the polynomial-from-roots block: sequences update steps and emission.
// Depends on crp_pkg for the command and status structs.
module crp_ctrl import crp_pkg::*; #(
	parameter int MAX_ROOTS = 16,
	localparam int IDX_W = $clog2(MAX_ROOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_root,
	output logic             in_ready,
	input  crp_status_t      status,
	output crp_cmd_t         cmd,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] step_addr,
	output logic [IDX_W-1:0] out_index
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_UPDATE  = 5'b00010,
		S_DRAIN   = 5'b00100,
		S_EMIT_RD = 5'b01000,
		S_EMIT_LD = 5'b10000
	} crp_state_t;

	localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_ROOTS);
	localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

	crp_state_t       state_q, state_d;
	logic [IDX_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] p_q, p_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             first_q, first_d;
	logic             last_q, last_d;
	logic             ovf_q, ovf_d;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		p_d       = p_q;
		idx_d     = idx_q;
		first_d   = first_q;
		last_d    = last_q;
		ovf_d     = ovf_q | status.sat;
		cmd       = '0;
		rd_addr   = idx_q;
		step_addr = p_q;
		out_index = idx_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.root_load = 1'b1;
					last_d        = last_root;
					if (count_q < MAX_CNT) begin
						count_d = count_q + ONE_IDX;
						p_d     = count_q + ONE_IDX;
						first_d = 1'b1;
						state_d = S_UPDATE;
					end else begin
						// The store is full: the root is dropped and flagged.
						ovf_d = 1'b1;
						if (last_root) begin
							idx_d   = '0;
							state_d = S_EMIT_RD;
						end
					end
				end
			end
			S_UPDATE: begin
				cmd.step_issue = 1'b1;
				cmd.step_first = first_q;
				rd_addr        = p_q - ONE_IDX;
				first_d        = 1'b0;
				if (p_q == ONE_IDX) begin
					state_d = S_DRAIN;
				end else begin
					p_d = p_q - ONE_IDX;
				end
			end
			S_DRAIN: begin
				if (!status.busy) begin
					idx_d   = '0;
					state_d = last_q ? S_EMIT_RD : S_IDLE;
				end
			end
			S_EMIT_RD: begin
				cmd.emit_read = 1'b1;
				state_d       = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (idx_q == count_q);
					cmd.out_ovf  = ovf_q;
					if (idx_q == count_q) begin
						// Run complete: the store returns to the polynomial 1.
						count_d = '0;
						ovf_d   = 1'b0;
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + ONE_IDX;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			p_q     <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
			last_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			p_q     <= p_d;
			idx_q   <= idx_d;
			first_q <= first_d;
			last_q  <= last_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

/* hdl/crp_datapath.sv */
// Datapath of the polynomial-from-roots block: coefficient memory, complex
// multiply-subtract pipeline and output register. Depends on crp_pkg and crp_if.
module crp_datapath import crp_pkg::*; #(
	parameter int MAX_ROOTS  = 16,
	parameter int COEF_WIDTH = 48,
	parameter int FRAC_BITS  = 14,
	localparam int IDX_W = $clog2(MAX_ROOTS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [ROOT_W-1:0] root_real,
	input  logic signed [ROOT_W-1:0] root_imag,
	input  crp_cmd_t                 cmd,
	input  logic [IDX_W-1:0]         rd_addr,
	input  logic [IDX_W-1:0]         step_addr,
	input  logic [IDX_W-1:0]         out_index,
	output crp_status_t              status,
	crp_coef_if.source               coef
);

	localparam int DEPTH = MAX_ROOTS + 1;
	localparam int CW    = COEF_WIDTH;
	localparam int PW    = CW + ROOT_W;   // one product
	localparam int SW    = PW + 1;        // sum of two products
	localparam int DW    = SW + 1;        // coefficient minus rounded product
	localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [CW-1:0] SAT_MAX  = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0] SAT_MIN  = {1'b1, {(CW - 1){1'b0}}};

	// Entry 0 is never written: a read of it yields the leading one in its place.
	logic [2*CW-1:0] store_q [DEPTH];

	logic signed [ROOT_W-1:0] root_re_q, root_im_q;

	// Stage 1: memory read data.
	logic [2*CW-1:0]  rd_s1;
	logic             zero_s1, first_s1, v_s1;
	logic [IDX_W-1:0] wa_s1;
	logic signed [CW-1:0] prev_re_s1, prev_im_s1;
	logic signed [CW-1:0] hold_re_q, hold_im_q;

	// Stage 2: products.
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [CW-1:0] cur_re_s2, cur_im_s2;
	logic [IDX_W-1:0]     wa_s2;
	logic                 v_s2;

	// Stage 3: rounded products, then subtract, saturate and write.
	logic signed [SW-1:0] sum_re, sum_im;
	logic signed [SW-1:0] t_re_s3, t_im_s3;
	logic signed [CW-1:0] cur_re_s3, cur_im_s3;
	logic [IDX_W-1:0]     wa_s3;
	logic                 v_s3;
	logic signed [DW-1:0] diff_re, diff_im;
	logic                 fit_re, fit_im;
	logic signed [CW-1:0] new_re, new_im;

	logic [INDEX_W+IDX_W-1:0] index_ext;

	assign prev_re_s1 = zero_s1 ? COEF_ONE : signed'(rd_s1[2*CW-1:CW]);
	assign prev_im_s1 = zero_s1 ? '0 : signed'(rd_s1[CW-1:0]);

	assign sum_re = SW'(p_rr_s2) - SW'(p_ii_s2) + RND_HALF;
	assign sum_im = SW'(p_ri_s2) + SW'(p_ir_s2) + RND_HALF;

	assign diff_re = DW'(cur_re_s3) - DW'(t_re_s3);
	assign diff_im = DW'(cur_im_s3) - DW'(t_im_s3);
	assign fit_re  = (&diff_re[DW-1:CW-1]) || !(|diff_re[DW-1:CW-1]);
	assign fit_im  = (&diff_im[DW-1:CW-1]) || !(|diff_im[DW-1:CW-1]);
	assign new_re  = fit_re ? diff_re[CW-1:0] : (diff_re[DW-1] ? SAT_MIN : SAT_MAX);
	assign new_im  = fit_im ? diff_im[CW-1:0] : (diff_im[DW-1] ? SAT_MIN : SAT_MAX);

	assign index_ext = (INDEX_W + IDX_W)'(out_index);

	assign status.busy     = v_s1 | v_s2 | v_s3;
	assign status.sat      = v_s3 & (!fit_re | !fit_im);
	assign status.out_free = !coef.valid || coef.ready;

	// Coefficient memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			store_q[wa_s3] <= {new_re, new_im};
		end
		if (cmd.step_issue || cmd.emit_read) begin
			rd_s1   <= store_q[rd_addr];
			zero_s1 <= (rd_addr == '0);
		end
	end

	// Payload registers of the pipeline and the output register.
	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			root_re_q <= root_real;
			root_im_q <= root_imag;
		end
		if (cmd.step_issue) begin
			first_s1 <= cmd.step_first;
			wa_s1    <= step_addr;
		end
		if (v_s1) begin
			p_rr_s2   <= PW'(prev_re_s1 * root_re_q);
			p_ii_s2   <= PW'(prev_im_s1 * root_im_q);
			p_ri_s2   <= PW'(prev_im_s1 * root_re_q);
			p_ir_s2   <= PW'(prev_re_s1 * root_im_q);
			// The value read for the step above is this step's own old coefficient.
			cur_re_s2 <= first_s1 ? '0 : hold_re_q;
			cur_im_s2 <= first_s1 ? '0 : hold_im_q;
			hold_re_q <= prev_re_s1;
			hold_im_q <= prev_im_s1;
			wa_s2     <= wa_s1;
		end
		if (v_s2) begin
			t_re_s3   <= sum_re >>> FRAC_BITS;
			t_im_s3   <= sum_im >>> FRAC_BITS;
			cur_re_s3 <= cur_re_s2;
			cur_im_s3 <= cur_im_s2;
			wa_s3     <= wa_s2;
		end
		if (cmd.out_load) begin
			coef.coef_index <= index_ext[INDEX_W-1:0];
			coef.coef_real  <= prev_re_s1;
			coef.coef_imag  <= prev_im_s1;
			coef.last_coef  <= cmd.out_last;
			coef.overflow   <= cmd.out_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			coef.valid <= 1'b0;
		end else begin
			v_s1 <= cmd.step_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.out_load) begin
				coef.valid <= 1'b1;
			end else if (coef.ready) begin
				coef.valid <= 1'b0;
			end
		end
	end

endmodule
